// ===== src/grg_pkg.sv =====
`default_nettype none

package grg_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int OUT_BITS      = 16;
    localparam int IDX_BITS      = $clog2(MAX_POINTS);
    localparam int COUNT_BITS    = 11;
    localparam int GAMMA_BITS    = 16;
    localparam int GAMMA_FRAC    = 12;
    localparam int CFG_ADDR_BITS = 3;
    localparam int FRAC_BITS     = 20;
    localparam int LOG_INT_BITS  = $clog2(IDX_BITS);
    localparam int LOG_BITS      = LOG_INT_BITS + FRAC_BITS;
    localparam int MANT_BITS     = 31;
    localparam int NUM_BITS      = LOG_BITS + GAMMA_FRAC;
    localparam int QINT_BITS     = NUM_BITS - FRAC_BITS;
    localparam int PROD_BITS     = OUT_BITS + MANT_BITS;
    localparam int Q_LIMIT       = 63 - (MANT_BITS - 1);

    localparam int LOG_STAGES = FRAC_BITS + 1;
    localparam int DIV_STAGES = NUM_BITS + 1;
    localparam int EXP_STAGES = FRAC_BITS + 3;

    localparam logic [OUT_BITS-1:0] FULL_SCALE = '1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_GAMMA_VALUE = 3'd0,
        REG_GAMMA_LOWER = 3'd1,
        REG_GAMMA_UPPER = 3'd2,
        REG_POINT_COUNT = 3'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } side_t;

    typedef logic [MANT_BITS-1:0] root_tab_t [1:FRAC_BITS];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] x;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        x    = v;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Roots 2^(-2^-k) in Q1.30, each the truncated square root of the one before.
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int k = 1; k <= FRAC_BITS; k++) begin
            tab[k] = r[MANT_BITS-1:0];
            r = isqrt64(r << 30);
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

// ===== src/grg_log2.sv =====
`default_nettype none

module grg_log2
    import grg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  side_t               in_side,
    input  logic [IDX_BITS-1:0] in_idx,
    input  logic [IDX_BITS-1:0] in_last,
    output side_t               out_side,
    output logic [LOG_BITS-1:0] out_log_idx,
    output logic [LOG_BITS-1:0] out_log_last
);

    side_t                   side_reg [0:FRAC_BITS];
    side_t                   side_next[0:FRAC_BITS];
    logic [MANT_BITS-1:0]    ma_reg   [0:FRAC_BITS];
    logic [MANT_BITS-1:0]    ma_next  [0:FRAC_BITS];
    logic [MANT_BITS-1:0]    mb_reg   [0:FRAC_BITS];
    logic [MANT_BITS-1:0]    mb_next  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]    fa_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]    fa_next  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]    fb_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]    fb_next  [0:FRAC_BITS];
    logic [LOG_INT_BITS-1:0] pa_reg   [0:FRAC_BITS];
    logic [LOG_INT_BITS-1:0] pa_next  [0:FRAC_BITS];
    logic [LOG_INT_BITS-1:0] pb_reg   [0:FRAC_BITS];
    logic [LOG_INT_BITS-1:0] pb_next  [0:FRAC_BITS];

    function automatic logic [LOG_INT_BITS-1:0] msb_pos(input logic [IDX_BITS-1:0] v);
        logic [LOG_INT_BITS-1:0] p;
        p = '0;
        for (int i = 1; i < IDX_BITS; i++) begin
            if (v[i]) begin
                p = LOG_INT_BITS'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [MANT_BITS-1:0] normalize(input logic [IDX_BITS-1:0] v,
                                                       input logic [LOG_INT_BITS-1:0] p);
        logic [MANT_BITS-1:0] w;
        w = MANT_BITS'(v) << (MANT_BITS - 1 - int'(p));
        return w;
    endfunction

    // One squaring step: returns the fraction bit above the new Q1.30 mantissa.
    function automatic logic [MANT_BITS:0] square_step(input logic [MANT_BITS-1:0] m);
        logic [2*MANT_BITS-1:0] sq;
        logic [MANT_BITS:0]     t;
        sq = (2*MANT_BITS)'(m) * (2*MANT_BITS)'(m);
        t  = sq[2*MANT_BITS-1:MANT_BITS-1];
        if (t[MANT_BITS]) begin
            return {1'b1, t[MANT_BITS:1]};
        end
        return {1'b0, t[MANT_BITS-1:0]};
    endfunction

    always_comb
    begin
        logic [MANT_BITS:0] sa;
        logic [MANT_BITS:0] sb;
        side_next[0] = in_side;
        pa_next[0]   = msb_pos(in_idx);
        pb_next[0]   = msb_pos(in_last);
        ma_next[0]   = normalize(in_idx, pa_next[0]);
        mb_next[0]   = normalize(in_last, pb_next[0]);
        fa_next[0]   = '0;
        fb_next[0]   = '0;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            sa = square_step(ma_reg[k-1]);
            sb = square_step(mb_reg[k-1]);
            side_next[k] = side_reg[k-1];
            pa_next[k]   = pa_reg[k-1];
            pb_next[k]   = pb_reg[k-1];
            ma_next[k]   = sa[MANT_BITS-1:0];
            mb_next[k]   = sb[MANT_BITS-1:0];
            fa_next[k]   = {fa_reg[k-1][FRAC_BITS-2:0], sa[MANT_BITS]};
            fb_next[k]   = {fb_reg[k-1][FRAC_BITS-2:0], sb[MANT_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                side_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= FRAC_BITS; k++) begin
            ma_reg[k] <= ma_next[k];
            mb_reg[k] <= mb_next[k];
            fa_reg[k] <= fa_next[k];
            fb_reg[k] <= fb_next[k];
            pa_reg[k] <= pa_next[k];
            pb_reg[k] <= pb_next[k];
        end
    end

    assign out_side     = side_reg[FRAC_BITS];
    assign out_log_idx  = {pa_reg[FRAC_BITS], fa_reg[FRAC_BITS]};
    assign out_log_last = {pb_reg[FRAC_BITS], fb_reg[FRAC_BITS]};

    // The logarithm is monotonic, so an index below the last point never yields a larger log.
    a_log_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_side.valid && out_side.kind == KIND_NORMAL) |-> (out_log_last >= out_log_idx))
        else $error("log of index exceeds log of last point");

endmodule

`default_nettype wire

// ===== src/grg_div.sv =====
`default_nettype none

module grg_div
    import grg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  side_t                 in_side,
    input  logic [LOG_BITS-1:0]   in_log_idx,
    input  logic [LOG_BITS-1:0]   in_log_last,
    input  logic [GAMMA_BITS-1:0] gamma,
    output side_t                 out_side,
    output logic [NUM_BITS-1:0]   out_expo
);

    side_t                 side_reg [0:NUM_BITS];
    side_t                 side_next[0:NUM_BITS];
    logic [GAMMA_BITS-1:0] rem_reg  [0:NUM_BITS];
    logic [GAMMA_BITS-1:0] rem_next [0:NUM_BITS];
    logic [NUM_BITS-1:0]   nq_reg   [0:NUM_BITS];
    logic [NUM_BITS-1:0]   nq_next  [0:NUM_BITS];

    // Restoring division, one quotient bit per stage. The word nq shifts the
    // dividend out at the top while quotient bits enter at the bottom.
    always_comb
    begin
        logic [GAMMA_BITS:0] t;
        logic                ge;
        side_next[0] = in_side;
        rem_next[0]  = '0;
        nq_next[0]   = {in_log_last - in_log_idx, GAMMA_FRAC'(0)};
        for (int k = 1; k <= NUM_BITS; k++) begin
            t  = {rem_reg[k-1], nq_reg[k-1][NUM_BITS-1]};
            ge = (t >= {1'b0, gamma});
            side_next[k] = side_reg[k-1];
            rem_next[k]  = ge ? GAMMA_BITS'(t - {1'b0, gamma}) : t[GAMMA_BITS-1:0];
            nq_next[k]   = {nq_reg[k-1][NUM_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= NUM_BITS; k++) begin
                side_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k <= NUM_BITS; k++) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NUM_BITS; k++) begin
            rem_reg[k] <= rem_next[k];
            nq_reg[k]  <= nq_next[k];
        end
    end

    assign out_side = side_reg[NUM_BITS];
    assign out_expo = nq_reg[NUM_BITS];

endmodule

`default_nettype wire

// ===== src/grg_exp.sv =====
`default_nettype none

module grg_exp
    import grg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  side_t               in_side,
    input  logic [NUM_BITS-1:0] in_expo,
    output logic                out_valid,
    output logic [OUT_BITS-1:0] out_value
);

    side_t                side_reg [0:FRAC_BITS];
    side_t                side_next[0:FRAC_BITS];
    logic [FRAC_BITS-1:0] f_reg    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] f_next   [0:FRAC_BITS];
    logic [QINT_BITS-1:0] q_reg    [0:FRAC_BITS];
    logic [QINT_BITS-1:0] q_next   [0:FRAC_BITS];
    logic [MANT_BITS-1:0] p_reg    [0:FRAC_BITS];
    logic [MANT_BITS-1:0] p_next   [0:FRAC_BITS];

    side_t                side_m_reg;
    logic [QINT_BITS-1:0] q_m_reg;
    logic [PROD_BITS-1:0] prod_m_reg;
    logic                 valid_reg;
    logic [OUT_BITS-1:0]  value_reg;
    logic [OUT_BITS-1:0]  value_next;

    // Each set fraction bit multiplies in the matching root of one half.
    always_comb
    begin
        logic [2*MANT_BITS-1:0] prod;
        side_next[0] = in_side;
        f_next[0]    = in_expo[FRAC_BITS-1:0];
        q_next[0]    = in_expo[NUM_BITS-1:FRAC_BITS];
        p_next[0]    = MANT_BITS'(1) << (MANT_BITS - 1);
        for (int k = 1; k <= FRAC_BITS; k++) begin
            prod = (2*MANT_BITS)'(p_reg[k-1]) * (2*MANT_BITS)'(ROOT_TAB[k]);
            side_next[k] = side_reg[k-1];
            f_next[k]    = f_reg[k-1];
            q_next[k]    = q_reg[k-1];
            p_next[k]    = f_reg[k-1][FRAC_BITS-k] ? prod[2*MANT_BITS-2:MANT_BITS-1]
                                                   : p_reg[k-1];
        end
    end

    always_comb
    begin
        logic [PROD_BITS-1:0] shifted;
        shifted = prod_m_reg >> (MANT_BITS - 1 + int'(q_m_reg));
        case (side_m_reg.kind)
            KIND_ZERO: value_next = '0;
            KIND_FULL: value_next = FULL_SCALE;
            default:   value_next = (q_m_reg > QINT_BITS'(Q_LIMIT)) ? '0
                                                                    : shifted[OUT_BITS-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                side_reg[k] <= '0;
            end
            side_m_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                side_reg[k] <= side_next[k];
            end
            side_m_reg <= side_reg[FRAC_BITS];
            valid_reg  <= side_m_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= FRAC_BITS; k++) begin
            f_reg[k] <= f_next[k];
            q_reg[k] <= q_next[k];
            p_reg[k] <= p_next[k];
        end
        q_m_reg    <= q_reg[FRAC_BITS];
        prod_m_reg <= PROD_BITS'(FULL_SCALE) * PROD_BITS'(p_reg[FRAC_BITS]);
        value_reg  <= value_next;
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

// ===== src/gamma_ramp_generator.sv =====
`default_nettype none

// Gamma ramp entry generator. Pulse start with a ramp index and, once the index
// has passed through the pipeline, done is high for one cycle with the corrected
// level on ramp_value. A new index may be issued every cycle; busy never rises.
// The stages are one capture, 21 of logarithm (normalize, then one squaring
// each), 37 of division (load, then one quotient bit each) and 23 of exponential
// and scaling (load, one root multiply each, then scale and select). The receiver
// cannot stall, so results must be taken in the cycle they appear. Write the
// configuration registers only while no transaction is in flight.
module gamma_ramp_generator
    import grg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic [IDX_BITS-1:0]      ramp_index,
    output logic [OUT_BITS-1:0]      ramp_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [GAMMA_BITS-1:0]    cfg_data
);

    localparam int LATENCY = 1 + LOG_STAGES + DIV_STAGES + EXP_STAGES;

    logic [GAMMA_BITS-1:0] gamma_value_reg;
    logic [GAMMA_BITS-1:0] gamma_lower_reg;
    logic [GAMMA_BITS-1:0] gamma_upper_reg;
    logic [COUNT_BITS-1:0] point_count_reg;
    logic [GAMMA_BITS-1:0] gamma_clamp_reg;
    logic [GAMMA_BITS-1:0] gamma_clamp_next;
    logic [IDX_BITS-1:0]   last_point;

    side_t                 side_in_reg;
    side_t                 side_in_next;
    logic [IDX_BITS-1:0]   idx_in_reg;
    logic [IDX_BITS-1:0]   last_in_reg;

    side_t                 log_side;
    logic [LOG_BITS-1:0]   log_idx;
    logic [LOG_BITS-1:0]   log_last;
    side_t                 div_side;
    logic [NUM_BITS-1:0]   div_expo;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gamma_value_reg <= GAMMA_BITS'(4096);
            gamma_lower_reg <= GAMMA_BITS'(2048);
            gamma_upper_reg <= GAMMA_BITS'(12288);
            point_count_reg <= COUNT_BITS'(256);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAMMA_VALUE: gamma_value_reg <= cfg_data;
                REG_GAMMA_LOWER: gamma_lower_reg <= cfg_data;
                REG_GAMMA_UPPER: gamma_upper_reg <= cfg_data;
                REG_POINT_COUNT: point_count_reg <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The upper limit is applied last, so it wins when the limits cross.
    always_comb
    begin
        gamma_clamp_next = gamma_value_reg;
        if (gamma_clamp_next < gamma_lower_reg) begin
            gamma_clamp_next = gamma_lower_reg;
        end
        if (gamma_clamp_next > gamma_upper_reg) begin
            gamma_clamp_next = gamma_upper_reg;
        end
        if (gamma_clamp_next == '0) begin
            gamma_clamp_next = GAMMA_BITS'(1);
        end
    end

    always_comb
    begin
        logic [COUNT_BITS-1:0] count;
        count = point_count_reg;
        if (count < COUNT_BITS'(2)) begin
            count = COUNT_BITS'(2);
        end
        if (count > COUNT_BITS'(MAX_POINTS)) begin
            count = COUNT_BITS'(MAX_POINTS);
        end
        last_point = IDX_BITS'(count - COUNT_BITS'(1));
    end

    always_comb
    begin
        side_in_next.valid = start && !busy;
        if (ramp_index == '0) begin
            side_in_next.kind = KIND_ZERO;
        end else if (ramp_index >= last_point) begin
            side_in_next.kind = KIND_FULL;
        end else begin
            side_in_next.kind = KIND_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_in_reg     <= '0;
            gamma_clamp_reg <= GAMMA_BITS'(4096);
        end else begin
            side_in_reg     <= side_in_next;
            gamma_clamp_reg <= gamma_clamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_in_reg  <= ramp_index;
        last_in_reg <= last_point;
    end

    grg_log2 u_log2 (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_side      (side_in_reg),
        .in_idx       (idx_in_reg),
        .in_last      (last_in_reg),
        .out_side     (log_side),
        .out_log_idx  (log_idx),
        .out_log_last (log_last)
    );

    grg_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_side     (log_side),
        .in_log_idx  (log_idx),
        .in_log_last (log_last),
        .gamma       (gamma_clamp_reg),
        .out_side    (div_side),
        .out_expo    (div_expo)
    );

    grg_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_side   (div_side),
        .in_expo   (div_expo),
        .out_valid (done),
        .out_value (ramp_value)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result did not appear after the pipeline latency");

    a_gamma_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gamma_clamp_reg != '0)
        else $error("divisor gamma is zero");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("unexpected result strobe");

endmodule

`default_nettype wire
